>>> design/hed_pkg.sv
// Package for the HTML entity decoder: sizes, codes, the named entity table
// and the types shared between the decoder modules. No dependencies.
`timescale 1ns / 1ps

package hed_pkg;

  localparam int NAME_BYTES  = 8;
  localparam int NAME_COUNT  = 38;
  localparam int COUNT_W     = 5;
  localparam int CODE_W      = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [CODE_W-1:0]  CODE_MAX    = 21'h10FFFF;
  localparam logic [CODE_W-1:0]  BMP_MAX     = 21'h00FFFF;
  localparam logic [CODE_W-1:0]  SUPP_BASE   = 21'h010000;
  localparam logic [15:0]        HIGH_SURR   = 16'hD800;
  localparam logic [15:0]        LOW_SURR    = 16'hDC00;
  localparam logic [9:0]         SURR_MASK   = 10'h3FF;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_LX   = 8'h78;
  localparam logic [7:0] CHAR_UX   = 8'h58;

  localparam logic OUTCOME_DECODED = 1'b0;
  localparam logic OUTCOME_UNKNOWN = 1'b1;

  typedef enum logic [1:0] {
    RADIX_NONE    = 2'd0,
    RADIX_DEC     = 2'd1,
    RADIX_HEX     = 2'd2,
    RADIX_NOT_NUM = 2'd3
  } radix_e;

  typedef logic [NAME_BYTES-1:0][7:0] name_buf_t;

  typedef struct packed {
    radix_e              radix;
    logic [CODE_W-1:0]   accum;
    logic                bad_digit;
    logic                too_large;
  } num_state_t;

  // Name text is right-aligned: the first character sits in the highest
  // occupied byte, as a string literal lands in a vector.
  localparam logic [NAME_BYTES*8-1:0] NAME_TEXT [NAME_COUNT] = '{
    "&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;", "&copy;", "&reg;",
    "&trade;", "&mdash;", "&ndash;", "&laquo;", "&raquo;", "&lsquo;",
    "&rsquo;", "&ldquo;", "&rdquo;", "&bull;", "&hellip;", "&rarr;", "&larr;",
    "&uarr;", "&darr;", "&times;", "&divide;", "&plusmn;", "&infin;", "&ne;",
    "&le;", "&ge;", "&deg;", "&micro;", "&para;", "&sect;", "&cent;",
    "&pound;", "&euro;", "&yen;"
  };

  localparam logic [COUNT_W-1:0] NAME_LEN [NAME_COUNT] = '{
    5'd5, 5'd4, 5'd4, 5'd6, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd6, 5'd8, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd8, 5'd7, 5'd4,
    5'd4, 5'd4, 5'd5, 5'd7, 5'd6, 5'd6, 5'd6,
    5'd7, 5'd6, 5'd5
  };

  localparam logic [15:0] NAME_UNIT [NAME_COUNT] = '{
    16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h00A0, 16'h00A9,
    16'h00AE, 16'h2122, 16'h2014, 16'h2013, 16'h00AB, 16'h00BB, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2026, 16'h2192, 16'h2190,
    16'h2191, 16'h2193, 16'h00D7, 16'h00F7, 16'h00B1, 16'h221E, 16'h2260,
    16'h2264, 16'h2265, 16'h00B0, 16'h00B5, 16'h00B6, 16'h00A7, 16'h00A2,
    16'h00A3, 16'h20AC, 16'h00A5
  };

endpackage

>>> design/hed_name_match.sv
// Named entity lookup: exact compare of the kept entity bytes against the
// fixed name table. Depends on hed_pkg.
`timescale 1ns / 1ps

module hed_name_match (
  input  hed_pkg::name_buf_t             buf_i,
  input  logic [hed_pkg::COUNT_W-1:0]    pos_i,
  output logic                           hit_o,
  output logic [15:0]                    unit_o
);
  import hed_pkg::*;

  logic [COUNT_W-1:0] size;
  logic               same;

  assign size = pos_i + 5'd1;

  // Names are unique, so at most one entry can hit.
  always_comb begin
    hit_o  = 1'b0;
    unit_o = '0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      same = (size == NAME_LEN[k]);
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (i < int'(NAME_LEN[k])) begin
          if (buf_i[i] != NAME_TEXT[k][(int'(NAME_LEN[k]) - 1 - i) * 8 +: 8]) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        hit_o  = 1'b1;
        unit_o = NAME_UNIT[k];
      end
    end
  end

endmodule

>>> design/hed_numeric.sv
// Numeric character reference tracking: radix detection and the decimal or
// hex code point accumulator with its error flags. Depends on hed_pkg.
`timescale 1ns / 1ps

module hed_numeric (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         last_i,
  input  logic [7:0]                   byte_i,
  input  logic [hed_pkg::COUNT_W-1:0]  pos_i,
  output hed_pkg::num_state_t          state_o
);
  import hed_pkg::*;

  radix_e             radix_q, radix_d;
  logic [CODE_W-1:0]  accum_q, accum_d;
  logic               bad_q, bad_d;
  logic               large_q, large_d;

  logic               take;
  logic               take_dec;
  logic               is_dec;
  logic               is_hex;
  logic [3:0]         digit;
  logic [CODE_W+3:0]  next_val;

  assign state_o = '{radix: radix_q, accum: accum_q, bad_digit: bad_q, too_large: large_q};

  // Digit decode for the radix that this byte is read in.
  always_comb begin
    is_dec = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    is_hex = 1'b1;
    digit  = byte_i[3:0];
    if (is_dec) begin
      digit = byte_i[3:0];
    end else if ((byte_i >= 8'h61) && (byte_i <= 8'h66)) begin
      digit = 4'(byte_i[3:0] + 4'd9);
    end else if ((byte_i >= 8'h41) && (byte_i <= 8'h46)) begin
      digit = 4'(byte_i[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    radix_d  = radix_q;
    take     = 1'b0;
    take_dec = 1'b0;
    if (pos_i == 5'd0) begin
      if (byte_i != CHAR_AMP) radix_d = RADIX_NOT_NUM;
    end else if (pos_i == 5'd1) begin
      if (radix_q == RADIX_NONE && byte_i != CHAR_HASH) radix_d = RADIX_NOT_NUM;
    end else if (pos_i == 5'd2) begin
      if (radix_q == RADIX_NONE) begin
        if (byte_i == CHAR_LX || byte_i == CHAR_UX) begin
          radix_d = RADIX_HEX;
        end else begin
          radix_d  = RADIX_DEC;
          take     = 1'b1;
          take_dec = 1'b1;
        end
      end
    end else if (radix_q == RADIX_DEC || radix_q == RADIX_HEX) begin
      take     = 1'b1;
      take_dec = (radix_q == RADIX_DEC);
    end
  end

  always_comb begin
    if (take_dec) begin
      next_val = {3'b000, accum_q, 1'b0} + {accum_q, 3'b000} + {21'd0, digit};
    end else begin
      next_val = {accum_q, 4'b0000} + {21'd0, digit};
    end
  end

  always_comb begin
    accum_d = accum_q;
    bad_d   = bad_q;
    large_d = large_q;
    if (take) begin
      if (take_dec ? !is_dec : !is_hex) begin
        bad_d = 1'b1;
      end else if (!large_q) begin
        if (next_val > {4'b0000, CODE_MAX}) begin
          large_d = 1'b1;
        end else begin
          accum_d = next_val[CODE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_NONE;
      accum_q <= '0;
      bad_q   <= 1'b0;
      large_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        radix_q <= RADIX_NONE;
        accum_q <= '0;
        bad_q   <= 1'b0;
        large_q <= 1'b0;
      end else begin
        radix_q <= radix_d;
        accum_q <= accum_d;
        bad_q   <= bad_d;
        large_q <= large_d;
      end
    end
  end

  a_accum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_q <= CODE_MAX)
    else $error("code point accumulator above the Unicode range");

  a_no_digits_outside_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_q == RADIX_NONE || radix_q == RADIX_NOT_NUM) |-> (accum_q == '0 && !bad_q && !large_q))
    else $error("digit state changed outside a numeric reference");

  a_entity_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (radix_q == RADIX_NONE && accum_q == '0))
    else $error("numeric state not cleared after the closing byte");

endmodule

>>> design/html_entity_decoder.sv
// HTML character reference decoder, top level. Depends on hed_pkg,
// hed_name_match and hed_numeric.
`timescale 1ns / 1ps

// Takes one entity byte per item, from '&' through the byte flagged final,
// and gives one result item per entity: a named or numeric reference as one
// UTF-16 unit or a surrogate pair, or a not-recognized status. The block
// takes one item every cycle while in_stall_o is low. An item sits in the
// input register while the name table compare and the digit accumulate run,
// and the result of a final byte is loaded into the output register when
// that byte advances, and can be taken from there. A final byte waits in
// the input register only while a previous result is still held by
// out_stall_i.
module html_entity_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  entity_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        outcome_o,
  output logic [1:0]  unit_count_o,
  output logic [15:0] first_unit_o,
  output logic [15:0] second_unit_o
);
  import hed_pkg::*;

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic               fin_q;
  logic               advance;
  logic               accept;

  logic [COUNT_W-1:0] count_q;
  name_buf_t          name_q;
  name_buf_t          name_d;

  logic               name_hit;
  logic [15:0]        name_unit;
  num_state_t         num;
  logic               num_ok;
  logic [CODE_W-1:0]  cp_off;

  logic               out_valid_q;
  logic               outcome_q, outcome_d;
  logic [1:0]         count_out_q, count_out_d;
  logic [15:0]        first_q, first_d;
  logic [15:0]        second_q, second_d;

  // A non-final item always retires; a final one needs room for its result.
  assign advance    = in_valid_q && (!fin_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= entity_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  // Buffer as it stands once the current byte is written at its position.
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++) begin
      name_d[i] = (count_q == COUNT_W'(i)) ? byte_q : name_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      name_q  <= '0;
    end else if (advance) begin
      if (fin_q) begin
        count_q <= '0;
        name_q  <= '0;
      end else begin
        name_q <= name_d;
        if (count_q != COUNT_MAX) count_q <= count_q + 5'd1;
      end
    end
  end

  hed_name_match u_name_match (
    .buf_i  (name_d),
    .pos_i  (count_q),
    .hit_o  (name_hit),
    .unit_o (name_unit)
  );

  hed_numeric u_numeric (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .last_i  (fin_q),
    .byte_i  (byte_q),
    .pos_i   (count_q),
    .state_o (num)
  );

  // Numeric references need at least four bytes in all.
  assign num_ok = (count_q >= 5'd3) &&
                  (num.radix == RADIX_DEC || num.radix == RADIX_HEX) &&
                  !num.bad_digit && !num.too_large && (num.accum != '0);
  assign cp_off = num.accum - SUPP_BASE;

  always_comb begin
    outcome_d   = OUTCOME_UNKNOWN;
    count_out_d = 2'd0;
    first_d     = '0;
    second_d    = '0;
    if (name_hit) begin
      outcome_d   = OUTCOME_DECODED;
      count_out_d = 2'd1;
      first_d     = name_unit;
    end else if (num_ok) begin
      outcome_d = OUTCOME_DECODED;
      if (num.accum <= BMP_MAX) begin
        count_out_d = 2'd1;
        first_d     = num.accum[15:0];
      end else begin
        count_out_d = 2'd2;
        first_d     = HIGH_SURR + {6'd0, cp_off[19:10]};
        second_d    = LOW_SURR + {6'd0, cp_off[9:0] & SURR_MASK};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && fin_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fin_q) begin
      outcome_q   <= outcome_d;
      count_out_q <= count_out_d;
      first_q     <= first_d;
      second_q    <= second_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign unit_count_o  = count_out_q;
  assign first_unit_o  = first_q;
  assign second_unit_o = second_q;

  a_unknown_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUTCOME_UNKNOWN) |->
      (unit_count_o == 2'd0 && first_unit_o == '0 && second_unit_o == '0))
    else $error("not-recognized result carries code units");

  a_decoded_has_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUTCOME_DECODED) |->
      (unit_count_o == 2'd1 || unit_count_o == 2'd2))
    else $error("decoded result without code units");

  a_pair_is_surrogates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unit_count_o == 2'd2) |->
      (first_unit_o[15:10] == 6'b110110 && second_unit_o[15:10] == 6'b110111))
    else $error("two-unit result is not a surrogate pair");

  a_entity_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fin_q) |=> (count_q == '0 && name_q == '0))
    else $error("entity state not cleared after the closing byte");

endmodule
